[sv/calendar_day_rule_resolver_core_macros.svh]
// Assertion macros shared by the calendar day rule resolver RTL.
`ifndef CALENDAR_DAY_RULE_RESOLVER_CORE_MACROS_SVH
`define CALENDAR_DAY_RULE_RESOLVER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define CDR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cdr: implication check failed");

`define CDR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cdr: next-cycle check failed");

`else

`define CDR_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define CDR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/cdr_pkg.sv]
// Shared types, codes and calendar tables for the day rule resolver.
`default_nettype none

package cdr_pkg;

	typedef enum logic [1:0] {
		OP_FIXED  = 2'd0,
		OP_LAST   = 2'd1,
		OP_AFTER  = 2'd2,
		OP_BEFORE = 2'd3
	} op_t;

	localparam logic [2:0] WD_INVALID = 3'd7;

	// floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT for y < 16384
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	typedef struct packed {
		op_t         op;
		logic [13:0] year;
		logic [3:0]  month;
		logic [2:0]  target_weekday;
		logic [4:0]  day_number;
	} query_t;

	typedef struct packed {
		op_t         op;
		logic [2:0]  target_weekday;
		logic [4:0]  day;
		logic [14:0] base;
	} cal_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] target_weekday;
		logic [4:0] day;
		logic [2:0] weekday;
	} wd_t;

	function automatic logic [2:0] month_offset(input logic [3:0] m);
		logic [2:0] r;
		unique case (m)
			4'd1:    r = 3'd0;
			4'd2:    r = 3'd3;
			4'd3:    r = 3'd2;
			4'd4:    r = 3'd5;
			4'd5:    r = 3'd0;
			4'd6:    r = 3'd3;
			4'd7:    r = 3'd5;
			4'd8:    r = 3'd1;
			4'd9:    r = 3'd4;
			4'd10:   r = 3'd6;
			4'd11:   r = 3'd2;
			4'd12:   r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] m);
		logic [4:0] r;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd2:    r = 5'd28;
			default: r = 5'd30;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/cdr_calendar.sv]
// Stages 1-2: year quotients, leap rule, month length and weekday base sum.
`default_nettype none
`include "calendar_day_rule_resolver_core_macros.svh"

module cdr_calendar
	import cdr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire query_t in_data,
	output logic        out_valid,
	input  wire logic   out_ready,
	output cal_t        out_data
);

	logic        valid_s1;
	query_t      q_s1;
	logic [26:0] prod_s1;
	logic        valid_s2;
	cal_t        cal_s2;
	logic        ready_s2;

	logic [7:0]  q100;
	logic [14:0] hund;
	logic        rem0;
	logic        leap;
	logic        adj;
	logic [13:0] ym1;
	logic [13:0] y;
	logic [7:0]  q100a;
	logic [2:0]  off;
	logic [4:0]  len;
	cal_t        cal_d;

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	always_comb begin
		q100  = prod_s1[RECIP_SHIFT +: 8];
		hund  = {7'd0, q100} * 15'd100;
		rem0  = hund == {1'b0, q_s1.year};
		leap  = (q_s1.year[1:0] == 2'b00) && (!rem0 || (q100[1:0] == 2'b00));
		adj   = (q_s1.month == 4'd1) || (q_s1.month == 4'd2);
		ym1   = q_s1.year - 14'd1;
		y     = adj ? ym1 : q_s1.year;
		q100a = q100 - {7'd0, adj && rem0};
		off   = month_offset(q_s1.month);
		if (q_s1.month == 4'd2) begin
			len = leap ? 5'd29 : 5'd28;
		end else begin
			len = month_length(q_s1.month);
		end
		cal_d.op             = q_s1.op;
		cal_d.target_weekday = q_s1.target_weekday;
		cal_d.day            = (q_s1.op == OP_LAST) ? len : q_s1.day_number;
		if (adj && (q_s1.year == 14'd0)) begin
			// adjusted year -1: quotients are zero, -1 taken as 6 mod 7
			cal_d.base = 15'd6 + {12'd0, off};
		end else begin
			cal_d.base = {1'b0, y} + {3'd0, y[13:2]} - {7'd0, q100a}
				+ {9'd0, q100a[7:2]} + {12'd0, off};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			q_s1    <= in_data;
			prod_s1 <= {13'd0, in_data.year} * {14'd0, RECIP_100};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			cal_s2 <= cal_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = cal_s2;

	`CDR_ASSERT_IMP(a_last_len, clk, arst_n, valid_s2 && (cal_s2.op == OP_LAST), (cal_s2.day >= 5'd28) && (cal_s2.day <= 5'd31))

endmodule

`default_nettype wire

[sv/cdr_weekday.sv]
// Stage 3: day sum and reduction modulo 7 to a weekday.
`default_nettype none
`include "calendar_day_rule_resolver_core_macros.svh"

module cdr_weekday
	import cdr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cal_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output wd_t       out_data
);

	logic        valid_s3;
	wd_t         wd_s3;
	logic [14:0] s;
	logic [5:0]  dsum;
	logic [3:0]  fold;
	wd_t         wd_d;

	assign in_ready = !valid_s3 || out_ready;

	// 8 = 1 mod 7: sum octal digits, then fold once more
	always_comb begin
		s    = in_data.base + {10'd0, in_data.day};
		dsum = {3'd0, s[2:0]} + {3'd0, s[5:3]} + {3'd0, s[8:6]}
			+ {3'd0, s[11:9]} + {3'd0, s[14:12]};
		fold = {1'b0, dsum[5:3]} + {1'b0, dsum[2:0]};
		wd_d.op             = in_data.op;
		wd_d.target_weekday = in_data.target_weekday;
		wd_d.day            = in_data.day;
		wd_d.weekday        = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			wd_s3 <= wd_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = wd_s3;

	`CDR_ASSERT_IMP(a_weekday_range, clk, arst_n, valid_s3, wd_s3.weekday != 3'd7)

endmodule

`default_nettype wire

[sv/cdr_resolve.sv]
// Stage 4: rule selection and output register.
`default_nettype none
`include "calendar_day_rule_resolver_core_macros.svh"

module cdr_resolve
	import cdr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire wd_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [6:0] out_day
);

	logic       valid_s4;
	logic [6:0] day_s4;
	logic [3:0] back4;
	logic [3:0] fwd4;
	logic [2:0] back;
	logic [2:0] fwd;
	logic [6:0] dayx;
	logic       bad_wd;
	logic [6:0] r;

	assign in_ready = !valid_s4 || out_ready;

	always_comb begin
		back4  = {1'b0, in_data.weekday} + 4'd7 - {1'b0, in_data.target_weekday};
		fwd4   = {1'b0, in_data.target_weekday} + 4'd7 - {1'b0, in_data.weekday};
		back   = (back4 >= 4'd7) ? 3'(back4 - 4'd7) : back4[2:0];
		fwd    = (fwd4 >= 4'd7) ? 3'(fwd4 - 4'd7) : fwd4[2:0];
		dayx   = {2'd0, in_data.day};
		bad_wd = in_data.target_weekday == WD_INVALID;
		unique case (in_data.op)
			OP_FIXED:  r = (in_data.day == 5'd0) ? 7'd1 : dayx;
			OP_LAST:   r = bad_wd ? 7'd1 : dayx - {4'd0, back};
			OP_AFTER:  r = (bad_wd || in_data.day == 5'd0) ? 7'd1 : dayx + {4'd0, fwd};
			OP_BEFORE: r = (bad_wd || in_data.day == 5'd0) ? 7'd1 : dayx - {4'd0, back};
			default:   r = 7'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			day_s4 <= r;
		end
	end

	assign out_valid = valid_s4;
	assign out_day   = day_s4;

	`CDR_ASSERT_IMP(a_day_range, clk, arst_n, valid_s4, ($signed(day_s4) >= -7'sd5) && ($signed(day_s4) <= 7'sd37))

endmodule

`default_nettype wire

[sv/calendar_day_rule_resolver_core.sv]
// Top level of the calendar day rule resolver.
//
// Input stream s_*: one rule query per transfer, s_tdata bits from the lowest:
//   op[1:0], year[15:2], month[19:16], target_weekday[22:20], day_number[27:23].
// Output stream m_*: one resolved day per query, m_tdata[6:0] two's complement
//   day of month, m_tdata[7] zero. Results leave in query order.
// Pipeline of four register stages: year quotients via reciprocal multiply,
//   leap rule and weekday base sum, modulo-7 weekday, rule selection.
// Throughput: one query per cycle while m_tready stays high.
// Each stage holds its item while the next one is full and stalled, so a receiver stall
//   backs up stage by stage; empty stages keep taking transfers. Nothing is
//   dropped or repeated.
// Reset (arst_n low) empties all stages; m_tvalid goes low at once.
`default_nettype none
`include "calendar_day_rule_resolver_core_macros.svh"

module calendar_day_rule_resolver_core
	import cdr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // op, year, month, target_weekday, day_number
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // day_of_month, zero pad
);

	query_t     query;
	logic       cal_valid;
	logic       cal_ready;
	cal_t       cal_data;
	logic       wd_valid;
	logic       wd_ready;
	wd_t        wd_data;
	logic [6:0] day;

	always_comb begin
		query.op             = op_t'(s_tdata[1:0]);
		query.year           = s_tdata[15:2];
		query.month          = s_tdata[19:16];
		query.target_weekday = s_tdata[22:20];
		query.day_number     = s_tdata[27:23];
	end

	cdr_calendar u_calendar (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (query),
		.out_valid (cal_valid),
		.out_ready (cal_ready),
		.out_data  (cal_data)
	);

	cdr_weekday u_weekday (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cal_valid),
		.in_ready  (cal_ready),
		.in_data   (cal_data),
		.out_valid (wd_valid),
		.out_ready (wd_ready),
		.out_data  (wd_data)
	);

	cdr_resolve u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (wd_valid),
		.in_ready  (wd_ready),
		.in_data   (wd_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_day   (day)
	);

	assign m_tdata = {1'b0, day};

	`CDR_ASSERT_IMP(a_empty_out_ready, clk, arst_n, !m_tvalid, s_tready && cal_ready && wd_ready)

endmodule

`default_nettype wire
